// File: rtl/core/xmodem_checksum_receiver_macros.svh
// ----------------------------------------------------------------------------
// XMODEM checksum receiver assertion macros
// Shorthand for the clocked checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef XMODEM_CHECKSUM_RECEIVER_MACROS_SVH
`define XMODEM_CHECKSUM_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XCR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("xcr check failed");

// The consequent must hold in the cycle after the antecedent.
`define XCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("xcr check failed");

`endif

// File: rtl/core/xcr_pkg.sv
// ----------------------------------------------------------------------------
// xcr_pkg
// Types, protocol characters and result codes shared by the receiver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xcr_pkg;

    localparam int unsigned BLOCK_BYTES = 128;
    localparam int unsigned IDX_BITS    = $clog2(BLOCK_BYTES);
    localparam int unsigned TOTAL_BITS  = 20;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_ALL = 8'hFF;

    localparam logic [31:0] NAK_INTERVAL_RESET = 32'd2000000;

    typedef enum logic [2:0] {
        ACT_STORE  = 3'd0,
        ACT_ACK    = 3'd1,
        ACT_NAK    = 3'd2,
        ACT_FINISH = 3'd3,
        ACT_ABORT  = 3'd4
    } t_action;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_NUM    = 6'b000010,
        PH_COMP   = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_SUM    = 6'b010000,
        PH_END    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic                  valid;
        t_action               action;
        logic [TOTAL_BITS-1:0] offset;
        logic [7:0]            data;
        logic [TOTAL_BITS-1:0] total;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/xcr_in_stage.sv
// ----------------------------------------------------------------------------
// xcr_in_stage
// Input register: holds one received byte or tick until the protocol takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xcr_in_stage import xcr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_cmd,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_advance,
    output logic            o_fire,
    output logic            o_cmd,
    output logic [7:0]      o_rx_byte
);

    logic       r_valid;
    logic       n_valid;
    logic       r_cmd;
    logic [7:0] r_byte;
    logic       accept;

    // The held item leaves whenever the result side can move.
    assign o_in_stall = r_valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_fire     = r_valid && i_advance;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_fire) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_cmd  <= i_cmd;
            r_byte <= i_rx_byte;
        end
    end

    assign o_cmd     = r_cmd;
    assign o_rx_byte = r_byte;

endmodule

`default_nettype wire

// File: rtl/core/xcr_protocol.sv
// ----------------------------------------------------------------------------
// xcr_protocol
// Packet state and the update for each byte or tick, taken when the held item fires.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xcr_protocol import xcr_pkg::*; #(
    parameter int unsigned ADDR_BITS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [31:0] i_nak_interval,
    output t_result          o_res
);

    localparam int unsigned MASK_BITS = (ADDR_BITS < TOTAL_BITS) ? ADDR_BITS : TOTAL_BITS;
    localparam logic [TOTAL_BITS-1:0] OFF_MASK =
        TOTAL_BITS'((64'd1 << MASK_BITS) - 64'd1);

    t_phase                r_phase,    n_phase;
    logic [7:0]            r_expected, n_expected;
    logic                  r_started,  n_started;
    logic [7:0]            r_hdr_num,  n_hdr_num;
    logic                  r_bad,      n_bad;
    logic [IDX_BITS-1:0]   r_idx,      n_idx;
    logic [7:0]            r_sum,      n_sum;
    logic [TOTAL_BITS-1:0] r_total,    n_total;
    logic [31:0]           r_idle,     n_idle;
    logic [31:0]           idle_inc;
    logic [TOTAL_BITS-1:0] offset;
    t_result               res;

    assign idle_inc = r_idle + 32'd1;
    assign offset   = (r_total + TOTAL_BITS'(r_idx)) & OFF_MASK;

    always_comb begin
        n_phase    = r_phase;
        n_expected = r_expected;
        n_started  = r_started;
        n_hdr_num  = r_hdr_num;
        n_bad      = r_bad;
        n_idx      = r_idx;
        n_sum      = r_sum;
        n_total    = r_total;
        n_idle     = r_idle;
        res        = '0;
        res.action = ACT_STORE;

        if (i_cmd) begin
            // Ticks only matter while waiting for the very first header.
            if (r_phase == PH_HEADER && !r_started) begin
                n_idle = idle_inc;
                if (idle_inc >= i_nak_interval) begin
                    n_idle     = '0;
                    res.valid  = 1'b1;
                    res.action = ACT_NAK;
                end
            end
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    n_idle = '0;
                    if (i_rx_byte == CH_EOT) begin
                        n_phase    = PH_END;
                        res.valid  = 1'b1;
                        res.action = ACT_FINISH;
                        res.total  = r_total;
                    end else if (i_rx_byte == CH_CAN) begin
                        n_phase    = PH_END;
                        res.valid  = 1'b1;
                        res.action = ACT_ABORT;
                    end else if (i_rx_byte == CH_SOH) begin
                        n_started = 1'b1;
                        n_bad     = 1'b0;
                        n_phase   = PH_NUM;
                    end else if (r_started) begin
                        n_phase    = PH_END;
                        res.valid  = 1'b1;
                        res.action = ACT_ABORT;
                    end
                end
                PH_NUM: begin
                    n_hdr_num = i_rx_byte;
                    if (i_rx_byte != r_expected) begin
                        n_bad = 1'b1;
                    end
                    n_phase = PH_COMP;
                end
                PH_COMP: begin
                    if ((r_hdr_num ^ i_rx_byte) != CH_ALL) begin
                        n_bad = 1'b1;
                    end
                    n_idx   = '0;
                    n_sum   = '0;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    n_sum = r_sum + i_rx_byte;
                    if (&r_idx) begin
                        n_phase = PH_SUM;
                    end else begin
                        n_idx = r_idx + IDX_BITS'(1);
                    end
                    res.valid  = 1'b1;
                    res.action = ACT_STORE;
                    res.offset = offset;
                    res.data   = i_rx_byte;
                end
                PH_SUM: begin
                    n_phase   = PH_HEADER;
                    res.valid = 1'b1;
                    if (r_bad || (r_sum != i_rx_byte)) begin
                        res.action = ACT_NAK;
                    end else begin
                        res.action = ACT_ACK;
                        n_expected = r_expected + 8'd1;
                        n_total    = r_total + TOTAL_BITS'(BLOCK_BYTES);
                    end
                end
                PH_END: begin
                    n_phase = PH_END;
                end
                default: begin
                    n_phase = PH_END;
                end
            endcase
        end

        // Once finished or aborted, nothing changes until reset.
        if (r_phase == PH_END) begin
            n_phase = PH_END;
            n_idle  = r_idle;
            res     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_expected <= 8'd1;
            r_started  <= 1'b0;
            r_hdr_num  <= '0;
            r_bad      <= 1'b0;
            r_idx      <= '0;
            r_sum      <= '0;
            r_total    <= '0;
            r_idle     <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_expected <= n_expected;
            r_started  <= n_started;
            r_hdr_num  <= n_hdr_num;
            r_bad      <= n_bad;
            r_idx      <= n_idx;
            r_sum      <= n_sum;
            r_total    <= n_total;
            r_idle     <= n_idle;
        end
    end

    always_comb begin
        o_res       = res;
        o_res.valid = res.valid && i_fire;
    end

endmodule

`default_nettype wire

// File: rtl/core/xcr_out_stage.sv
// ----------------------------------------------------------------------------
// xcr_out_stage
// Result register: presents one result and holds it while the sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xcr_out_stage import xcr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_result           i_res,
    output logic                   o_advance,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [2:0]             o_action,
    output logic [TOTAL_BITS-1:0]  o_store_offset,
    output logic [7:0]             o_store_data,
    output logic [TOTAL_BITS-1:0]  o_total_bytes
);

    logic                  r_valid;
    t_action               r_action;
    logic [TOTAL_BITS-1:0] r_offset;
    logic [7:0]            r_data;
    logic [TOTAL_BITS-1:0] r_total;

    assign o_advance = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res.valid;
        end
        if (o_advance && i_res.valid) begin
            r_action <= i_res.action;
            r_offset <= i_res.offset;
            r_data   <= i_res.data;
            r_total  <= i_res.total;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_action       = r_action;
    assign o_store_offset = r_offset;
    assign o_store_data   = r_data;
    assign o_total_bytes  = r_total;

endmodule

`default_nettype wire

// File: rtl/core/xmodem_checksum_receiver.sv
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver
// XMODEM receiver for 128-byte blocks with an arithmetic checksum.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   input    sink       i_in_valid / o_in_stall   i_cmd, i_rx_byte
//   result   source     o_out_valid / i_out_stall o_action, o_store_offset,
//                                                 o_store_data, o_total_bytes
//   config   sink       i_cfg_we                  i_cfg_wdata (nak_interval)
//
// One item is taken per cycle while the input is not stalled. An accepted
// item waits in the input register, where the protocol update works on it
// combinationally, and any result it causes is loaded into the result
// register when the item fires, that is when the result register can take it.
// Synchronous active-low reset returns to waiting for a header, expects
// block one and restores the NAK interval of 2000000 ticks.
// A stall on the result side holds the result register and the input item
// behind it; the input stalls only while both stages are full.
//
`timescale 1ns / 1ps
`default_nettype none

`include "xmodem_checksum_receiver_macros.svh"

module xmodem_checksum_receiver import xcr_pkg::*; #(
    parameter int unsigned ADDR_BITS = 20
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_cmd,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [2:0]             o_action,
    output logic [TOTAL_BITS-1:0]  o_store_offset,
    output logic [7:0]             o_store_data,
    output logic [TOTAL_BITS-1:0]  o_total_bytes,
    input  wire logic              i_cfg_we,
    input  wire logic [31:0]       i_cfg_wdata
);

    // Number of idle ticks before the initial NAK is repeated.
    logic [31:0] r_nak_interval;

    logic       advance;
    logic       fire;
    logic       held_cmd;
    logic [7:0] held_byte;
    t_result    res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nak_interval <= NAK_INTERVAL_RESET;
        end else if (i_cfg_we) begin
            r_nak_interval <= i_cfg_wdata;
        end
    end

    // The input register holds the next byte or tick.
    xcr_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_rx_byte  (i_rx_byte),
        .i_advance  (advance),
        .o_fire     (fire),
        .o_cmd      (held_cmd),
        .o_rx_byte  (held_byte)
    );

    // The protocol state advances by one item whenever the held item fires.
    xcr_protocol #(
        .ADDR_BITS (ADDR_BITS)
    ) u_proto (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_cmd          (held_cmd),
        .i_rx_byte      (held_byte),
        .i_nak_interval (r_nak_interval),
        .o_res          (res)
    );

    // The result register decouples the sink from the protocol update.
    xcr_out_stage u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_res          (res),
        .o_advance      (advance),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_action       (o_action),
        .o_store_offset (o_store_offset),
        .o_store_data   (o_store_data),
        .o_total_bytes  (o_total_bytes)
    );

    // Only a blocked result register may hold up the input side.
    `XCR_ASSERT_SAME(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // Only a store carries an offset and data.
    `XCR_ASSERT_SAME(a_store_fields, o_out_valid && (o_action != ACT_STORE),
        (o_store_offset == '0) && (o_store_data == '0))

    // Only a finish reports the byte total.
    `XCR_ASSERT_SAME(a_total_field, o_out_valid && (o_action != ACT_FINISH),
        o_total_bytes == '0)

    // After a finish or abort has been transferred, no further result follows.
    `XCR_ASSERT_NEXT(a_quiet_after_end,
        o_out_valid && !i_out_stall &&
        ((o_action == ACT_FINISH) || (o_action == ACT_ABORT)),
        !o_out_valid)

endmodule

`default_nettype wire
